/* rtl/tlbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_pkg
// Shared constants for the two-level branch predictor: field widths,
// request kind codes and the reset value of the address shift register.
// ----------------------------------------------------------------------------
package tlbp_pkg;

	localparam int ADDR_W  = 64;
	localparam int TAG_W   = 32;
	localparam int SHIFT_W = 2;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 2'd2;

	// request kinds
	localparam logic KIND_PREDICT = 1'b0;
	localparam logic KIND_UPDATE  = 1'b1;

endpackage : tlbp_pkg
`default_nettype wire

/* rtl/tlbp_way_logic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlbp_way_logic
// Tag compare over all ways of one history set, and the next contents of
// that set for an update: history shift on a hit, refill of the least
// recent way on a miss, and the move of the touched way to most recent.
// ----------------------------------------------------------------------------
module tlbp_way_logic
	import tlbp_pkg::*;
#(
	parameter int WAYS = 4,
	parameter int HB   = 10,
	parameter int WB   = 2
) (
	input  wire logic [WAYS*(TAG_W+1+HB+WB)-1:0] row_in,
	input  wire logic [TAG_W-1:0]                tag,
	input  wire logic                            taken,
	output logic                                 hit,
	output logic [HB-1:0]                        old_hist,
	output logic [WAYS*(TAG_W+1+HB+WB)-1:0]      row_out
);

	typedef struct packed {
		logic [WAYS-1:0][TAG_W-1:0] tags;
		logic [WAYS-1:0]            valid;
		logic [WAYS-1:0][HB-1:0]    hist;
		logic [WAYS-1:0][WB-1:0]    order;
	} row_t;

	row_t          cur;
	row_t          nxt;
	logic [WB-1:0] hit_way;
	logic [WB-1:0] sel_way;
	logic [WB-1:0] pos;

	assign cur = row_t'(row_in);

	// tags of valid ways are distinct, so at most one way matches
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (cur.valid[w] && cur.tags[w] == tag) begin
				hit     = 1'b1;
				hit_way = WB'(w);
			end
		end
	end

	assign old_hist = cur.hist[hit_way];
	assign sel_way  = hit ? hit_way : cur.order[0];

	always_comb begin
		pos = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (cur.order[i] == sel_way) begin
				pos = WB'(i);
			end
		end
	end

	always_comb begin
		nxt = cur;
		if (hit) begin
			nxt.hist[hit_way] = HB'({old_hist, taken});
		end else begin
			nxt.tags[sel_way]  = tag;
			nxt.valid[sel_way] = 1'b1;
			nxt.hist[sel_way]  = HB'(taken);
		end
		// close the gap at pos, put the touched way on top
		for (int i = 0; i < WAYS - 1; i++) begin
			nxt.order[i] = (WB'(i) < pos) ? cur.order[i] : cur.order[i+1];
		end
		nxt.order[WAYS-1] = sel_way;
	end

	assign row_out = nxt;

endmodule : tlbp_way_logic
`default_nettype wire

/* rtl/two_level_branch_predictor_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_branch_predictor_core
// Two-level adaptive branch predictor with per-address histories held in a
// set-associative history table (LRU) and one shared table of saturating
// pattern counters.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps both tables to their reset contents,
// holding busy high until all max(HISTORY_SETS, PATTERN_ENTRIES) entries are
// written. Then a word is taken whenever start is high while busy is low. A
// lookup or update that misses in the history table returns its result from
// the LOOK state; one that hits goes on to the PAT state, because the set
// row is read from the history memory first and only then the counter it
// selects is read (and for an update written back) in the pattern memory.
// The result shows on predict_taken and history_hit for one cycle with done
// high and cannot be held off; busy drops in that same cycle, so a new word
// may be started while the result is on the ports. addr_shift may be
// written through cfg_we/cfg_wdata only while no word is in flight.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_core
	import tlbp_pkg::*;
#(
	parameter int PATTERN_ENTRIES = 1024,
	parameter int HISTORY_SETS    = 256,
	parameter int WAYS            = 4,
	parameter int COUNTER_BITS    = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [SHIFT_W-1:0] cfg_wdata,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic [ADDR_W-1:0]  inst_addr,
	input  wire logic               taken,
	output logic                    done,
	output logic                    predict_taken,
	output logic                    history_hit
);

	// history length, set index and way number widths
	localparam int HB     = $clog2(PATTERN_ENTRIES);
	localparam int SB     = $clog2(HISTORY_SETS);
	localparam int SET_W  = (HISTORY_SETS > 1) ? SB : 1;
	localparam int WB     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W  = WAYS * (TAG_W + 1 + HB + WB);
	localparam int CLR_N  = (HISTORY_SETS > PATTERN_ENTRIES) ? HISTORY_SETS : PATTERN_ENTRIES;
	localparam int CLR_W  = $clog2(CLR_N);

	localparam logic [SET_W-1:0] SET_MASK = SET_W'(HISTORY_SETS - 1);

	// sequencer states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_PAT   = 2'd3;

	typedef struct packed {
		logic [WAYS-1:0][TAG_W-1:0] tags;
		logic [WAYS-1:0]            valid;
		logic [WAYS-1:0][HB-1:0]    hist;
		logic [WAYS-1:0][WB-1:0]    order;
	} row_t;

	// ---------------------------------------------------------------- state
	logic [1:0]             state_q;
	logic [CLR_W-1:0]       clr_q;
	logic [SHIFT_W-1:0]     addr_shift_q;

	logic                   kind_s1;
	logic                   taken_s1;
	logic [TAG_W-1:0]       tag_s1;
	logic [SET_W-1:0]       set_s1;
	logic [HB-1:0]          pat_addr_s2;

	logic                   done_q;
	logic                   predict_q;
	logic                   hit_q;

	// history table: one row per set, all ways side by side
	logic [ROW_W-1:0]        row_mem [HISTORY_SETS];
	logic [ROW_W-1:0]        row_rd;
	logic                    row_we;
	logic [SET_W-1:0]        row_waddr;
	logic [ROW_W-1:0]        row_wdata;

	// pattern table
	logic [COUNTER_BITS-1:0] pat_mem [PATTERN_ENTRIES];
	logic [COUNTER_BITS-1:0] pat_rd;
	logic                    pat_we;
	logic [HB-1:0]           pat_waddr;
	logic [COUNTER_BITS-1:0] pat_wdata;

	// ------------------------------------------------------ request decode
	logic                   accept;
	logic [ADDR_W-1:0]      shifted;
	logic [SET_W-1:0]       req_set;
	logic [TAG_W-1:0]       req_tag;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign shifted = inst_addr >> addr_shift_q;
	assign req_set = shifted[SET_W-1:0] & SET_MASK;
	assign req_tag = TAG_W'(shifted >> SB);

	// ------------------------------------------------------------ set logic
	logic             look_hit;
	logic [HB-1:0]    look_hist;
	logic [ROW_W-1:0] look_row;

	tlbp_way_logic #(
		.WAYS (WAYS),
		.HB   (HB),
		.WB   (WB)
	) u_way_logic (
		.row_in   (row_rd),
		.tag      (tag_s1),
		.taken    (taken_s1),
		.hit      (look_hit),
		.old_hist (look_hist),
		.row_out  (look_row)
	);

	// reset contents of a row: nothing valid, way 0 least recent
	row_t reset_row;

	always_comb begin
		reset_row = '0;
		for (int i = 0; i < WAYS; i++) begin
			reset_row.order[i] = WB'(i);
		end
	end

	// saturating counter step
	logic [COUNTER_BITS-1:0] ctr_next;

	always_comb begin
		ctr_next = pat_rd;
		if (taken_s1) begin
			if (pat_rd != '1) begin
				ctr_next = pat_rd + COUNTER_BITS'(1);
			end
		end else if (pat_rd != '0) begin
			ctr_next = pat_rd - COUNTER_BITS'(1);
		end
	end

	// ------------------------------------------------------- memory writes
	always_comb begin
		row_we    = 1'b0;
		row_waddr = set_s1;
		row_wdata = look_row;
		pat_we    = 1'b0;
		pat_waddr = pat_addr_s2;
		pat_wdata = ctr_next;
		unique case (state_q)
			ST_CLEAR: begin
				row_we    = (int'(clr_q) < HISTORY_SETS);
				row_waddr = clr_q[SET_W-1:0];
				row_wdata = reset_row;
				pat_we    = (int'(clr_q) < PATTERN_ENTRIES);
				pat_waddr = clr_q[HB-1:0];
				pat_wdata = '0;
			end
			ST_LOOK: begin
				// updates write the set back, hit or miss
				row_we = (kind_s1 == KIND_UPDATE);
			end
			ST_PAT: begin
				pat_we = (kind_s1 == KIND_UPDATE);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		if (accept) begin
			row_rd <= row_mem[req_set];
		end
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_waddr] <= pat_wdata;
		end
		if (state_q == ST_LOOK) begin
			pat_rd <= pat_mem[look_hist];
		end
	end

	// ------------------------------------------------------ payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			taken_s1 <= taken;
			tag_s1   <= req_tag;
			set_s1   <= req_set;
		end
		if (state_q == ST_LOOK) begin
			pat_addr_s2 <= look_hist;
		end
	end

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			addr_shift_q <= SHIFT_RESET;
			done_q       <= 1'b0;
			predict_q    <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				addr_shift_q <= cfg_wdata;
			end
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					// advance the sweep, leave on the last entry
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (look_hit) begin
						state_q <= ST_PAT;
					end else begin
						// miss: predict taken on lookups, done now
						state_q   <= ST_IDLE;
						done_q    <= 1'b1;
						predict_q <= (kind_s1 == KIND_PREDICT);
						hit_q     <= 1'b0;
					end
				end
				ST_PAT: begin
					state_q   <= ST_IDLE;
					done_q    <= 1'b1;
					predict_q <= (kind_s1 == KIND_PREDICT) && pat_rd[COUNTER_BITS-1];
					hit_q     <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign predict_taken = predict_q;
	assign history_hit   = hit_q;

endmodule : two_level_branch_predictor_core
`default_nettype wire

/* tb/tb_two_level_branch_predictor_core.sv */
// ----------------------------------------------------------------------------
// tb_two_level_branch_predictor_core
// Self-checking bench for the two-level branch predictor core. A behavioral
// copy of the history table, its LRU order and the pattern counters predicts
// every result; directed tests cover cold misses, counter training with
// saturation, LRU eviction and tag extremes, then random traffic over small
// address pools runs under shifts 0, 3 and 1 with varied start gaps.
// ----------------------------------------------------------------------------
module tb_two_level_branch_predictor_core;
	import tlbp_pkg::*;

	// Table geometry, kept equal to the defaults the core is built with.
	localparam int SETS     = 256;
	localparam int WAYS     = 4;
	localparam int PATTERNS = 1024;
	localparam int CTR_W    = 2;
	localparam int SET_W    = 8;
	localparam int HIST_W   = 10;
	localparam logic [CTR_W-1:0] CTR_MAX = '1;

	// Cycles with neither a word taken nor a result seen before the run is
	// called hung; this also covers the post-reset table sweep.
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic predict_taken;
		logic history_hit;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [SHIFT_W-1:0] cfg_wdata;
	logic               start;
	logic               busy;
	logic               kind;
	logic [ADDR_W-1:0]  inst_addr;
	logic               taken;
	logic               done;
	logic               predict_taken;
	logic               history_hit;

	two_level_branch_predictor_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.inst_addr     (inst_addr),
		.taken         (taken),
		.done          (done),
		.predict_taken (predict_taken),
		.history_hit   (history_hit)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the predictor state
	// ------------------------------------------------------------------
	logic [SHIFT_W-1:0] cur_shift;
	logic [TAG_W-1:0]   way_tag   [SETS*WAYS];
	logic               way_ok    [SETS*WAYS];
	logic [HIST_W-1:0]  way_hist  [SETS*WAYS];
	int                 lru_order [SETS][WAYS];
	logic [CTR_W-1:0]   pattern_ctr [PATTERNS];

	outcome_t pending_outcomes[$];

	int mismatches = 0;
	int n_lookups  = 0;
	int n_updates  = 0;
	int n_hits     = 0;
	int n_evicts   = 0;

	function automatic void clear_tables();
		cur_shift = SHIFT_RESET;
		for (int e = 0; e < SETS*WAYS; e++) begin
			way_tag[e]  = '0;
			way_ok[e]   = 1'b0;
			way_hist[e] = '0;
		end
		for (int s = 0; s < SETS; s++)
			for (int w = 0; w < WAYS; w++)
				lru_order[s][w] = w;
		for (int p = 0; p < PATTERNS; p++)
			pattern_ctr[p] = '0;
	endfunction

	// Move a way to the most recent end of its set's order.
	function automatic void touch_way(int s, int w);
		int pos;
		pos = 0;
		for (int i = 0; i < WAYS; i++)
			if (lru_order[s][i] == w)
				pos = i;
		for (int i = pos; i + 1 < WAYS; i++)
			lru_order[s][i] = lru_order[s][i+1];
		lru_order[s][WAYS-1] = w;
	endfunction

	// Apply one accepted word to the shadow state and return its result.
	function automatic outcome_t branch_outcome(logic k, logic [ADDR_W-1:0] a, logic t);
		logic [ADDR_W-1:0] sh;
		logic [TAG_W-1:0]  tg;
		logic [HIST_W-1:0] old_hist;
		int                set_idx, base, hw, victim;
		logic              hit;
		outcome_t          res;
		sh      = a >> cur_shift;
		set_idx = int'(sh[SET_W-1:0]);
		tg      = sh[SET_W +: TAG_W];
		base    = set_idx * WAYS;
		hit     = 1'b0;
		hw      = 0;
		// scan downward so the lowest matching way wins
		for (int w = WAYS - 1; w >= 0; w--)
			if (way_ok[base+w] && way_tag[base+w] == tg) begin
				hit = 1'b1;
				hw  = w;
			end
		res.history_hit   = hit;
		res.predict_taken = 1'b0;
		if (k == KIND_PREDICT) begin
			n_lookups++;
			res.predict_taken = hit ? pattern_ctr[way_hist[base+hw]][CTR_W-1] : 1'b1;
		end else if (hit) begin
			n_updates++;
			old_hist = way_hist[base+hw];
			way_hist[base+hw] = {old_hist[HIST_W-2:0], t};
			if (t && pattern_ctr[old_hist] != CTR_MAX)
				pattern_ctr[old_hist] = pattern_ctr[old_hist] + 1'b1;
			else if (!t && pattern_ctr[old_hist] != '0)
				pattern_ctr[old_hist] = pattern_ctr[old_hist] - 1'b1;
			touch_way(set_idx, hw);
		end else begin
			n_updates++;
			victim = lru_order[set_idx][0];
			if (way_ok[base+victim])
				n_evicts++;
			way_tag[base+victim]  = tg;
			way_ok[base+victim]   = 1'b1;
			way_hist[base+victim] = {{(HIST_W-1){1'b0}}, t};
			touch_way(set_idx, victim);
		end
		if (hit)
			n_hits++;
		return res;
	endfunction

	// Build an address whose set and tag land on the given values under the
	// current shift; bits below the shift and above the tag are random.
	function automatic logic [ADDR_W-1:0] make_addr(logic [SET_W-1:0] s, logic [TAG_W-1:0] tg);
		logic [ADDR_W-1:0] junk, field, mask;
		junk  = {$urandom, $urandom};
		mask  = {{(ADDR_W-TAG_W-SET_W){1'b0}}, {(TAG_W+SET_W){1'b1}}} << cur_shift;
		field = {{(ADDR_W-TAG_W-SET_W){1'b0}}, tg, s} << cur_shift;
		return (junk & ~mask) | field;
	endfunction

	// ------------------------------------------------------------------
	// Clock, result check, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sample at the rising edge: every done cycle carries one result word,
	// which must match the oldest expectation field by field.
	always @(posedge clk) begin
		outcome_t exp;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result word with no expectation pending: predict_taken=%0b history_hit=%0b",
					predict_taken, history_hit);
				mismatches++;
			end else begin
				exp = pending_outcomes.pop_front();
				if (predict_taken !== exp.predict_taken) begin
					$error("predict_taken: expected %0b, got %0b", exp.predict_taken,
						predict_taken);
					mismatches++;
				end
				if (history_hit !== exp.history_hit) begin
					$error("history_hit: expected %0b, got %0b", exp.history_hit, history_hit);
					mismatches++;
				end
			end
		end
	end

	// Reset the count on any handshake or result; end the run if it stalls.
	int stall_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_outcomes.size());
			$display("two_level_branch_predictor_core verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver tasks; all called at a falling edge
	// ------------------------------------------------------------------

	// Present one word, hold it until taken, then predict its result.
	task automatic send_word(logic k, logic [ADDR_W-1:0] a, logic t);
		start     = 1'b1;
		kind      = k;
		inst_addr = a;
		taken     = t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_outcomes.push_back(branch_outcome(k, a, t));
		@(negedge clk);
		start = 1'b0;
	endtask

	// Hold start low for a short random stretch with the given odds.
	task automatic idle_gap(int pct);
		if ($urandom_range(99) < pct)
			repeat ($urandom_range(1, 4)) @(negedge clk);
	endtask

	// Wait until every result is back and the core is idle, then settle.
	task automatic drain();
		while (pending_outcomes.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_shift(logic [SHIFT_W-1:0] v);
		drain();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(posedge clk);
		cur_shift = v;
		@(negedge clk);
		cfg_we    = 1'b0;
		cfg_wdata = SHIFT_W'($urandom);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty table: lookups miss and predict taken, including the all-zero
	// and all-ones addresses (the all-zero tag must not match an empty way).
	task automatic test_cold_miss();
		send_word(KIND_PREDICT, '0, 1'b0);
		send_word(KIND_PREDICT, '1, 1'b1);
	endtask

	// Drive counter 0 up to its maximum and back down to zero through
	// several branches whose history is all not-taken.
	task automatic test_counter_training();
		logic [ADDR_W-1:0] br [5];
		for (int i = 0; i < 5; i++)
			br[i] = make_addr(SET_W'(10 + i), TAG_W'(32'h0000_1234 + i));
		// fill: miss on update, history = not taken
		for (int i = 0; i < 4; i++)
			send_word(KIND_UPDATE, br[i], 1'b0);
		// taken with history zero: 0 -> 1 -> 2 -> 3 -> stays 3
		for (int i = 0; i < 4; i++)
			send_word(KIND_UPDATE, br[i], 1'b1);
		send_word(KIND_UPDATE, br[4], 1'b0);
		send_word(KIND_PREDICT, br[4], 1'b0);
		// not taken with history zero: 3 -> 2 -> 1 -> 0 -> stays 0
		repeat (4) send_word(KIND_UPDATE, br[4], 1'b0);
		send_word(KIND_PREDICT, br[4], 1'b1);
	endtask

	// Five tags in one set: the fifth evicts the least recent way.
	task automatic test_lru_eviction();
		logic [TAG_W-1:0] tags [5];
		tags = '{'1, '0, 32'h0000_00A5, 32'h5A5A_5A5A, 32'h8000_0001};
		for (int i = 0; i < 5; i++)
			send_word(KIND_UPDATE, make_addr(SET_W'(5), tags[i]), i[0]);
		send_word(KIND_PREDICT, make_addr(SET_W'(5), tags[0]), 1'b0);
		send_word(KIND_PREDICT, make_addr(SET_W'(5), tags[1]), 1'b1);
	endtask

	// Random traffic. Most words come from a small pool of set/tag pairs so
	// that hits, history growth and evictions happen; the rest are fully
	// random addresses. The taken bias shifts every chunk so counters walk
	// to both limits, and some chunks run with no gaps at all.
	task automatic test_random_traffic(int n_words, int gap_pct, logic [SHIFT_W-1:0] shift_val);
		logic [SET_W-1:0]  set_pool [4];
		logic [TAG_W-1:0]  tag_pool [6];
		logic [ADDR_W-1:0] a;
		logic              k, t;
		int                bias, pct;
		set_shift(shift_val);
		set_pool[0] = '0;
		set_pool[1] = '1;
		set_pool[2] = SET_W'($urandom);
		set_pool[3] = SET_W'($urandom);
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 6; i++)
			tag_pool[i] = $urandom;
		bias = 50;
		pct  = gap_pct;
		for (int i = 0; i < n_words; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(2))
					0: bias = 10;
					1: bias = 50;
					default: bias = 90;
				endcase
				pct = ($urandom_range(3) == 0) ? 0 : gap_pct;
			end
			if ($urandom_range(99) < 15)
				a = {$urandom, $urandom};
			else
				a = make_addr(set_pool[$urandom_range(3)], tag_pool[$urandom_range(5)]);
			k = ($urandom_range(99) < 40) ? KIND_PREDICT : KIND_UPDATE;
			t = ($urandom_range(99) < bias);
			idle_gap(pct);
			send_word(k, a, t);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// Drive every input known from time zero and hold reset.
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		start     = 1'b0;
		kind      = KIND_PREDICT;
		inst_addr = '0;
		taken     = 1'b0;
		clear_tables();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset shift, written explicitly once the
		// post-reset table sweep has finished.
		set_shift(SHIFT_RESET);
		test_cold_miss();
		test_counter_training();
		test_lru_eviction();

		// Random part: sender gaps 27%, then 52%, then none; cover the
		// extreme shifts and one in between.
		test_random_traffic(380, 27, 2'd0);
		test_random_traffic(380, 52, 2'd3);
		test_random_traffic(390, 0, 2'd1);

		drain();
		repeat (8) @(posedge clk);

		$display("covered %0d lookups and %0d updates: %0d history hits, %0d evictions",
			n_lookups, n_updates, n_hits, n_evicts);
		$display("address shifts 0 to 3 exercised, %0d field mismatches", mismatches);
		if (mismatches == 0)
			$display("two_level_branch_predictor_core verification clean");
		else
			$display("two_level_branch_predictor_core verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/tlbp_pkg.sv
rtl/tlbp_way_logic.sv
rtl/two_level_branch_predictor_core.sv
tb/tb_two_level_branch_predictor_core.sv
